// File: hdl/ffba_pkg.sv
// Shared types, sizes and helpers for the first-fit block allocator.
`default_nettype none

package ffba_pkg;

	localparam int DISK_BLOCKS = 1024;
	localparam int MAX_RUN     = 63;

	localparam int SIZE_W    = 32;
	localparam int HELD_W    = 11;
	localparam int BSZ_W     = 17;
	localparam int IDX_OUT_W = 10;

	localparam logic [BSZ_W-1:0] BLOCK_SIZE_RESET = BSZ_W'(512);

	localparam int WORD_BITS = 32;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int ROWS      = (DISK_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RUN_W     = $clog2(MAX_RUN + 1);

	localparam int DIV_STEPS = SIZE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_NONE  = 2'd2,
		STS_TRUNC = 2'd3
	} status_t;

	typedef struct packed {
		logic [SIZE_W-1:0] file_size;
		logic [HELD_W-1:0] blocks_held;
	} in_item_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] block_index;
		logic                 block_valid;
		status_t              status;
		logic                 last;
	} out_item_t;

	// Reset contents of one map row: a bit is free when its block exists.
	function automatic logic [WORD_BITS-1:0] row_init(input logic [ROW_W-1:0] row);
		logic [WORD_BITS-1:0] init;
		int base;
		base = int'(row) * WORD_BITS;
		for (int b = 0; b < WORD_BITS; b++) begin
			init[b] = (base + b) < DISK_BLOCKS;
		end
		return init;
	endfunction

endpackage

`default_nettype wire

// File: hdl/first_fit_block_allocator_core.sv
// First-fit block allocator: free map in a word-wide RAM, one block per result.
// Flow: the divider works out the need after the accepting edge; then each map row visited
// is read, loaded, scanned one claimed block at a time while the output register is free,
// until the row is empty or the need is met, and written back; a status result then
// closes the request. Throughput: one request at a time.
// Reset: async, active low; a clearing pass over all ROWS (32) rows then fills the map.
`default_nettype none

module first_fit_block_allocator_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [ffba_pkg::BSZ_W-1:0] cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire ffba_pkg::in_item_t        in_data,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output ffba_pkg::out_item_t            out_data
);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_DIV,
		S_RD,
		S_LD,
		S_SCAN,
		S_WB,
		S_STAT
	} state_t;

	state_t                          state_q;
	logic [ffba_pkg::BSZ_W-1:0]      block_size_q;
	logic [ffba_pkg::HELD_W-1:0]     held_q;
	logic [ffba_pkg::ROW_W-1:0]      row_q;
	logic [ffba_pkg::WORD_BITS-1:0]  word_q;
	logic [ffba_pkg::RUN_W-1:0]      run_q;
	logic [ffba_pkg::RUN_W-1:0]      want_q;
	logic                            trunc_q;
	ffba_pkg::status_t               stat_q;
	ffba_pkg::out_item_t             out_q;
	logic                            out_valid_q;

	// Free map: one bit per block, 1 = free, WORD_BITS blocks per row.
	logic [ffba_pkg::WORD_BITS-1:0] mem [ffba_pkg::ROWS];
	logic [ffba_pkg::WORD_BITS-1:0] rdata_s1;
	logic                           mem_we;
	logic                           mem_re;
	logic [ffba_pkg::WORD_BITS-1:0] mem_wdata;

	logic                         div_start;
	logic                         div_done;
	logic [ffba_pkg::SIZE_W-1:0]  div_quo;
	logic [ffba_pkg::BSZ_W-1:0]   divisor;

	logic                         in_xfer;
	logic                         slot_free;
	logic                         emit;
	logic                         row_last;
	logic [ffba_pkg::BIT_W-1:0]   low_bit;
	logic [ffba_pkg::ROW_W+ffba_pkg::BIT_W-1:0] idx_full;
	logic [ffba_pkg::SIZE_W-1:0]  held_ext;
	logic [ffba_pkg::SIZE_W-1:0]  need;
	logic                         need_none;
	logic                         need_trunc;

	// Lowest free bit of the working row.
	function automatic logic [ffba_pkg::BIT_W-1:0] lowest_set(
		input logic [ffba_pkg::WORD_BITS-1:0] w
	);
		logic [ffba_pkg::BIT_W-1:0] pos;
		pos = '0;
		for (int b = ffba_pkg::WORD_BITS - 1; b >= 0; b--) begin
			if (w[b]) begin
				pos = ffba_pkg::BIT_W'(b);
			end
		end
		return pos;
	endfunction

	// Accept a request only from idle; the block handles one request at a time.
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign div_start = in_xfer;
	// A block size of zero divides as one.
	assign divisor   = (block_size_q == '0) ? ffba_pkg::BSZ_W'(1) : block_size_q;

	ffba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_data.file_size),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// The output register is free when empty or when its result transfers now.
	assign slot_free = !out_valid_q || !out_stall;
	// A block claim or the closing status loads the output register.
	assign emit      = slot_free &&
	                   (((state_q == S_SCAN) && (word_q != '0)) || (state_q == S_STAT));
	assign row_last  = (row_q == ffba_pkg::ROW_W'(ffba_pkg::ROWS - 1));
	assign low_bit   = lowest_set(word_q);
	assign idx_full  = {row_q, low_bit};

	assign held_ext   = {{(ffba_pkg::SIZE_W - ffba_pkg::HELD_W){1'b0}}, held_q};
	assign need_none  = (held_ext >= div_quo);
	assign need       = div_quo - held_ext;
	assign need_trunc = (need > ffba_pkg::SIZE_W'(ffba_pkg::MAX_RUN));

	// Reads and writes never share a cycle: a row is read, edited in word_q,
	// then written back before the next row is read.
	assign mem_re    = (state_q == S_RD);
	assign mem_we    = (state_q == S_CLR) || (state_q == S_WB);
	assign mem_wdata = (state_q == S_CLR) ? ffba_pkg::row_init(row_q) : word_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[row_q] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[row_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= ffba_pkg::BLOCK_SIZE_RESET;
		end else if (cfg_we) begin
			block_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			row_q       <= '0;
			run_q       <= '0;
			want_q      <= '0;
			trunc_q     <= 1'b0;
			stat_q      <= ffba_pkg::STS_OK;
			out_valid_q <= 1'b0;
		end else begin
			// Hold a new result when one is emitted; drop the held one once it transfers.
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (row_last) begin
						row_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						held_q  <= in_data.blocks_held;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (need_none) begin
							stat_q  <= ffba_pkg::STS_NONE;
							state_q <= S_STAT;
						end else begin
							trunc_q <= need_trunc;
							want_q  <= need_trunc ? ffba_pkg::RUN_W'(ffba_pkg::MAX_RUN)
							                      : need[ffba_pkg::RUN_W-1:0];
							run_q   <= '0;
							row_q   <= '0;
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					word_q  <= rdata_s1;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (word_q == '0) begin
						state_q <= S_WB;
					end else if (slot_free) begin
						// Claim the lowest free block of this row.
						out_q.block_index <= ffba_pkg::IDX_OUT_W'(idx_full);
						out_q.block_valid <= 1'b1;
						out_q.status      <= ffba_pkg::STS_OK;
						out_q.last        <= 1'b0;
						word_q            <= word_q & (word_q - 1'b1);
						run_q             <= run_q + 1'b1;
						if (ffba_pkg::RUN_W'(run_q + 1'b1) == want_q) begin
							state_q <= S_WB;
						end
					end
				end
				S_WB: begin
					if (run_q == want_q) begin
						stat_q  <= trunc_q ? ffba_pkg::STS_TRUNC : ffba_pkg::STS_OK;
						state_q <= S_STAT;
					end else if (row_last) begin
						stat_q  <= ffba_pkg::STS_FULL;
						state_q <= S_STAT;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_STAT: begin
					if (slot_free) begin
						out_q.block_index <= '0;
						out_q.block_valid <= 1'b0;
						out_q.status      <= stat_q;
						out_q.last        <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// A result is either a claimed block or the closing status, never both.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.last != out_q.block_valid))
		else $error("result mixes block and status");

	// Block results carry status ok.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.block_valid) |-> (out_q.status == ffba_pkg::STS_OK))
		else $error("block result with nonzero status");

	// The map RAM is never read and written in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("map read and write collide");

	// The scan never claims past the capped need.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (run_q < want_q))
		else $error("claim count overran its limit");

	// A new request is held off while one is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("request accepted while busy");
`endif

endmodule

`default_nettype wire

// File: hdl/ffba_div.sv
// Radix-2 restoring divider: one quotient bit per cycle.
`default_nettype none

module ffba_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [ffba_pkg::SIZE_W-1:0] dividend,
	input  wire logic [ffba_pkg::BSZ_W-1:0]  divisor,
	output logic                            done,
	output logic [ffba_pkg::SIZE_W-1:0]      quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic [ffba_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [ffba_pkg::SIZE_W-1:0]    quo_q;
	logic [ffba_pkg::BSZ_W-1:0]     rem_q;
	logic [ffba_pkg::BSZ_W-1:0]     dsr_q;

	logic [ffba_pkg::BSZ_W:0] shifted;
	logic [ffba_pkg::BSZ_W:0] diff;
	logic                     ge;

	// Remainder stays below the divisor, so the difference sign is the borrow.
	assign shifted = {rem_q, quo_q[ffba_pkg::SIZE_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = ~diff[ffba_pkg::BSZ_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q &&
			          (cnt_q == ffba_pkg::DIV_CNT_W'(ffba_pkg::DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ffba_pkg::DIV_CNT_W'(ffba_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ffba_pkg::SIZE_W-2:0], ge};
			rem_q <= ge ? diff[ffba_pkg::BSZ_W-1:0] : shifted[ffba_pkg::BSZ_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: tb/tb_first_fit_block_allocator_core.sv
// Self-checking testbench for the first-fit block allocator core.
module tb_first_fit_block_allocator_core;
	import ffba_pkg::*;

	// Run limits. CYCLE_LIMIT covers the slowest correct run: at most 1024 block
	// results in total, a status result per request, the map scan of each
	// request and random stalls on both channels.
	localparam int CYCLE_LIMIT   = 500_000;
	localparam int SETTLE_CYCLES = 8;	// idle gap before a register write
	localparam int TAIL_CYCLES   = 250;	// quiet time after the last result
	localparam int HOLD_CYCLES   = 600;	// long receiver hold-off
	localparam int REPORT_MAX    = 10;

	// One row of the directed table. When typed is set, the expected transfers
	// are block_count blocks counted up from first_block and then final_status.
	typedef struct packed {
		logic              write_cfg;
		logic [BSZ_W-1:0]  cfg_value;
		logic [SIZE_W-1:0] file_size;
		logic [HELD_W-1:0] held;
		logic              typed;
		int                first_block;
		int                block_count;
		status_t           final_status;
	} directed_row_t;

	// Rows that claim blocks run against the map in order, so the typed block
	// numbers follow on from each other; the disk is never full in this part.
	localparam directed_row_t DIRECTED_ROWS [22] = '{
		// reset block size of 512: empty file, just below one block
		'{1'b0, 17'd0,      32'd0,          11'd0,    1'b1, 0,   0,  STS_NONE},
		'{1'b0, 17'd0,      32'd511,        11'd0,    1'b1, 0,   0,  STS_NONE},
		'{1'b0, 17'd0,      32'd512,        11'd0,    1'b1, 0,   1,  STS_OK},
		'{1'b0, 17'd0,      32'd1536,       11'd1,    1'b1, 1,   2,  STS_OK},
		// held equal to need, held at its maximum
		'{1'b0, 17'd0,      32'd2560,       11'd5,    1'b1, 0,   0,  STS_NONE},
		'{1'b0, 17'd0,      32'd2048,       11'd2047, 1'b1, 0,   0,  STS_NONE},
		// largest file, exactly a full run, one past a full run
		'{1'b0, 17'd0,      32'hFFFF_FFFF,  11'd0,    1'b1, 3,   63, STS_TRUNC},
		'{1'b0, 17'd0,      32'd32256,      11'd0,    1'b1, 66,  63, STS_OK},
		'{1'b0, 17'd0,      32'd33279,      11'd0,    1'b1, 129, 63, STS_TRUNC},
		// block size of one byte, held with its top bit set
		'{1'b1, 17'd1,      32'd5,          11'd2,    1'b1, 192, 3,  STS_OK},
		'{1'b0, 17'd0,      32'd1024,       11'd1024, 1'b1, 0,   0,  STS_NONE},
		'{1'b0, 17'd0,      32'd1030,       11'd1024, 1'b1, 195, 6,  STS_OK},
		// zero block size divides as one; both fields at their maximum
		'{1'b1, 17'd0,      32'd7,          11'd0,    1'b1, 201, 7,  STS_OK},
		'{1'b0, 17'd0,      32'd2050,       11'd2047, 1'b1, 208, 3,  STS_OK},
		'{1'b0, 17'd0,      32'hFFFF_FFFF,  11'd2047, 1'b1, 211, 63, STS_TRUNC},
		// largest block size in range
		'{1'b1, 17'd65536,  32'd65535,      11'd0,    1'b1, 0,   0,  STS_NONE},
		'{1'b0, 17'd0,      32'd327680,     11'd0,    1'b1, 274, 5,  STS_OK},
		'{1'b0, 17'd0,      32'd131072,     11'd1,    1'b1, 279, 1,  STS_OK},
		// block size above range is used as written
		'{1'b1, 17'd131071, 32'd393213,     11'd1,    1'b1, 280, 2,  STS_OK},
		'{1'b0, 17'd0,      32'd131070,     11'd0,    1'b1, 0,   0,  STS_NONE},
		// back to 512: these rows are checked by the predictor only
		'{1'b1, 17'd512,    32'd5220,       11'd3,    1'b0, 0,   0,  STS_OK},
		'{1'b0, 17'd0,      32'h0001_2345,  11'd100,  1'b0, 0,   0,  STS_OK}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [BSZ_W-1:0]  cfg_wdata;
	logic              in_valid;
	logic              in_stall;
	in_item_t          in_data;
	logic              out_valid;
	logic              out_stall;
	out_item_t         out_data;

	// Predictor state: free map (1 = free) and the block size register.
	logic [DISK_BLOCKS-1:0] free_blocks;
	logic [BSZ_W-1:0]       block_bytes;
	out_item_t              pending_results [$];

	// Traffic shaping, shared between the main sequence and the drivers.
	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;
	bit          hold_request;
	int          hold_left;

	int fail_count;
	int results_checked;
	int requests_sent;
	int blocks_claimed;
	int size_settings;
	int status_tally [4];
	int cycle_count;
	out_item_t head_result;

	first_fit_block_allocator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX) begin
			$display("ERROR @%0d cycles: %s", cycle_count, msg);
		end
	endfunction

	// Queue one expected transfer: a claimed block, or the closing status.
	function automatic void add_result(input int idx, input bit is_block, input status_t st,
			input bit enqueue);
		out_item_t r;
		r.block_index = is_block ? IDX_OUT_W'(idx) : '0;
		r.block_valid = is_block;
		r.status      = is_block ? STS_OK : st;
		r.last        = !is_block;
		if (enqueue) begin
			pending_results.push_back(r);
			if (is_block) begin
				blocks_claimed++;
			end else begin
				status_tally[st]++;
			end
		end
	endfunction

	// First-fit claim against the predicted map. Always update the map; queue
	// the expected transfers only when asked to.
	function automatic void claim_blocks(input in_item_t req, input bit enqueue);
		logic [SIZE_W-1:0] divisor;
		logic [SIZE_W-1:0] quotient;
		logic [SIZE_W-1:0] need;
		logic [SIZE_W-1:0] want;
		int                got;
		divisor  = (block_bytes == '0) ? SIZE_W'(1) : SIZE_W'(block_bytes);
		quotient = req.file_size / divisor;
		got      = 0;
		if (SIZE_W'(req.blocks_held) >= quotient) begin
			add_result(0, 1'b0, STS_NONE, enqueue);
			return;
		end
		need = quotient - SIZE_W'(req.blocks_held);
		want = (need > SIZE_W'(MAX_RUN)) ? SIZE_W'(MAX_RUN) : need;
		for (int b = 0; b < DISK_BLOCKS && SIZE_W'(got) < want; b++) begin
			if (free_blocks[b]) begin
				free_blocks[b] = 1'b0;
				add_result(b, 1'b1, STS_OK, enqueue);
				got++;
			end
		end
		if (SIZE_W'(got) < want) begin
			add_result(0, 1'b0, STS_FULL, enqueue);
		end else if (need > want) begin
			add_result(0, 1'b0, STS_TRUNC, enqueue);
		end else begin
			add_result(0, 1'b0, STS_OK, enqueue);
		end
	endfunction

	// Build a random request for the current block size. Mostly small, well-formed
	// needs; some that need nothing; rare fully random noise. Near the end of the
	// run, big needs join the mix so that the disk fills and runs dry.
	function automatic in_item_t make_request(input bit tail);
		in_item_t    r;
		int unsigned bs;
		int unsigned quot;
		int unsigned held;
		int unsigned pick;
		bs   = (block_bytes == '0) ? 1 : int'(block_bytes);
		pick = $urandom_range(99);
		if (pick < 2) begin
			r.file_size   = $urandom;
			r.blocks_held = HELD_W'($urandom);
			return r;
		end
		if (pick < 14) begin
			quot = $urandom_range(40);
			held = quot + ($urandom_range(1) ? 0 : $urandom_range(0, 2047 - quot));
		end else begin
			held = $urandom_range(60);
			if (tail && pick < 60) begin
				quot = held + $urandom_range(60, 300);
			end else begin
				quot = held + $urandom_range(1, 4);
			end
		end
		r.file_size   = SIZE_W'(quot * bs + $urandom_range(0, bs - 1));
		r.blocks_held = HELD_W'(held);
		return r;
	endfunction

	// Offer one request and return at the rising edge that takes the transfer.
	// Valid stays high afterward; the next offer or a drain decides its fate.
	task automatic offer_request(input in_item_t req);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = req;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		requests_sent++;
	endtask

	// Drop valid and wait until every expected transfer is back, then settle.
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the block size register while the core is idle.
	task automatic set_block_size(input logic [BSZ_W-1:0] value);
		drain_results();
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we      = 1'b0;
		block_bytes = value;
		size_settings++;
	endtask

	task automatic run_phase(input logic [BSZ_W-1:0] bsize, input int unsigned tx_pct,
			input int unsigned rx_pct, input int count, input bit hold, input bit tail);
		in_item_t req;
		set_block_size(bsize);
		sender_idle_pct    = tx_pct;
		receiver_stall_pct = rx_pct;
		hold_request       = hold;
		for (int n = 0; n < count; n++) begin
			req = make_request(tail);
			offer_request(req);
			claim_blocks(req, 1'b1);
		end
	endtask

	// Receiver: random stalls, plus a long hold-off on request so that the core
	// backs up and stalls its input side.
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request && hold_left == 0) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left != 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < receiver_stall_pct);
			end
		end
	end

	// Check every output transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result: idx %0d valid %0b status %0d last %0b",
					out_data.block_index, out_data.block_valid, out_data.status,
					out_data.last));
			end else begin
				head_result = pending_results.pop_front();
				if (out_data.block_index !== head_result.block_index ||
						out_data.block_valid !== head_result.block_valid ||
						out_data.status !== head_result.status ||
						out_data.last !== head_result.last) begin
					note_failure($sformatf({"result %0d: expected idx %0d valid %0b status %s",
						" last %0b, got idx %0d valid %0b status %0d last %0b"},
						results_checked, head_result.block_index, head_result.block_valid,
						head_result.status.name(), head_result.last, out_data.block_index,
						out_data.block_valid, out_data.status, out_data.last));
				end
			end
			results_checked++;
		end
	end

	// Watchdog: end the run if it hangs.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results still outstanding",
			cycle_count, pending_results.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		directed_row_t row;
		in_item_t      req;

		// Hold every input at a known value from time zero.
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		in_valid           = 1'b0;
		in_data            = '0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_request       = 1'b0;
		fail_count         = 0;
		results_checked    = 0;
		requests_sent      = 0;
		blocks_claimed     = 0;
		size_settings      = 0;
		status_tally       = '{default: 0};
		free_blocks        = '1;
		block_bytes        = BLOCK_SIZE_RESET;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: walk the table, running on the reset block size first.
		// The core's clearing pass after reset simply shows up as input stall.
		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			if (row.write_cfg) begin
				set_block_size(row.cfg_value);
			end
			req.file_size   = row.file_size;
			req.blocks_held = row.held;
			offer_request(req);
			if (row.typed) begin
				for (int b = row.first_block; b < row.first_block + row.block_count; b++) begin
					add_result(b, 1'b1, STS_OK, 1'b1);
				end
				add_result(0, 1'b0, row.final_status, 1'b1);
				claim_blocks(req, 1'b0);
			end else begin
				claim_blocks(req, 1'b1);
			end
		end

		// Random part, one phase per block size and traffic pattern. The last
		// phase drives big needs so the map runs out and reports a full disk.
		run_phase(BSZ_W'(512), 0, 0, 40, 1'b0, 1'b0);
		run_phase(BSZ_W'(1), 62, 0, 35, 1'b0, 1'b0);
		run_phase(BSZ_W'($urandom_range(2, 65535)), 0, 62, 35, 1'b0, 1'b0);
		run_phase(BSZ_W'(65536), 24, 24, 35, 1'b0, 1'b0);
		run_phase('0, 0, 0, 10, 1'b1, 1'b0);
		run_phase(BSZ_W'(131071), 30, 30, 45, 1'b0, 1'b1);

		// Wait out the last results, then stay quiet long enough to catch strays.
		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d requests over %0d block size settings: %0d blocks claimed,",
			requests_sent, size_settings, blocks_claimed);
		$display("%0d results checked; ok %0d, disk full %0d, nothing needed %0d, truncated %0d",
			results_checked, status_tally[STS_OK], status_tally[STS_FULL],
			status_tally[STS_NONE], status_tally[STS_TRUNC]);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d failures", fail_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
